FILE: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// The surrounding module must provide clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define KGAL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define KGAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/kgal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgal_pkg
// Types and constants of the kanji glyph address lookup.
// ----------------------------------------------------------------------------
package kgal_pkg;

  localparam int MAX_BLOCKS   = 128;
  localparam int HEADER_BYTES = 18;

  localparam int ADDR_W = 32;
  localparam int CODE_W = 16;
  localparam int IDX_W  = 7;
  localparam int BC_W   = 8;
  localparam int PIX_W  = 8;
  localparam int BPR_W  = 6;              // bytes per glyph row
  localparam int SIZE_W = BPR_W + PIX_W;  // bytes per glyph
  localparam int REG_W  = 3;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [REG_W-1:0] {
    CFG_FONT_BASE     = 3'd0,
    CFG_GLYPH_WIDTH   = 3'd1,
    CFG_GLYPH_HEIGHT  = 3'd2,
    CFG_BLOCK_COUNT   = 3'd3,
    CFG_FALLBACK_CODE = 3'd4
  } cfg_reg_t;

  // Search token travelling along the cell row. Before a hit, acc is the
  // running prefix of range sizes; after a hit it is the glyph index.
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [CODE_W-1:0] code;
    logic [ADDR_W-1:0] acc;
  } tok_t;

  // Range entry write broadcast to all cells.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  index;
    logic [CODE_W-1:0] first;
    logic [CODE_W-1:0] last;
  } load_t;

endpackage

FILE: sv/kgal_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgal_if
// Valid/ready channels of the kanji glyph address lookup.
// ----------------------------------------------------------------------------
interface kgal_req_if;
  import kgal_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [IDX_W-1:0]  block_index;
  logic [CODE_W-1:0] range_start;
  logic [CODE_W-1:0] range_end;
  logic [CODE_W-1:0] code;

  modport source (output valid, op, block_index, range_start, range_end, code,
                  input ready);
  modport sink (input valid, op, block_index, range_start, range_end, code,
                output ready);
endinterface

interface kgal_rsp_if;
  import kgal_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] glyph_address;
  logic              used_fallback;
  logic              not_found;

  modport source (output valid, glyph_address, used_fallback, not_found,
                  input ready);
  modport sink (input valid, glyph_address, used_fallback, not_found,
                output ready);
endinterface

interface kgal_cfg_if;
  import kgal_pkg::*;
  logic              valid;
  logic              ready;
  logic [REG_W-1:0]  reg_index;
  logic [ADDR_W-1:0] write_data;

  modport source (output valid, reg_index, write_data, input ready);
  modport sink (input valid, reg_index, write_data, output ready);
endinterface

FILE: sv/kgal_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgal_cell
// One code-range entry of the block table and one stage of the search row.
// ----------------------------------------------------------------------------
module kgal_cell
  import kgal_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic [BC_W-1:0] cell_id,
  input  logic [BC_W-1:0] block_count,
  input  load_t           load,
  input  tok_t            tok_in,
  output tok_t            tok_out
);

  logic [CODE_W-1:0] range_first;
  logic [CODE_W-1:0] range_last;

  logic              tok_valid;
  logic              tok_hit;
  logic [CODE_W-1:0] tok_code;
  logic [ADDR_W-1:0] tok_acc;

  logic              active;
  logic              in_range;
  logic [ADDR_W-1:0] delta;
  logic              hit_next;
  logic [ADDR_W-1:0] acc_next;

  // Entries at or beyond block_count are skipped; the token passes unchanged.
  assign active   = cell_id < block_count;
  assign in_range = (range_first <= tok_in.code) && (tok_in.code <= range_last);

  always_comb begin
    if (in_range) begin
      delta = ADDR_W'(tok_in.code) - ADDR_W'(range_first);
    end else begin
      // Wraps modulo 2^32 for a reversed range.
      delta = ADDR_W'(range_last) - ADDR_W'(range_first) + ADDR_W'(1);
    end
    hit_next = tok_in.hit;
    acc_next = tok_in.acc;
    if (active && !tok_in.hit) begin
      hit_next = in_range;
      acc_next = tok_in.acc + delta;
    end
  end

  always_ff @(posedge clk) begin
    if (load.we && (BC_W'(load.index) == cell_id)) begin
      range_first <= load.first;
      range_last  <= load.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else begin
      tok_valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_hit  <= hit_next;
    tok_code <= tok_in.code;
    tok_acc  <= acc_next;
  end

  assign tok_out = '{valid: tok_valid, hit: tok_hit, code: tok_code, acc: tok_acc};

endmodule

FILE: sv/kanji_glyph_address_lookup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kanji_glyph_address_lookup_top
// Glyph address unit for a double-byte font with a code-range block table.
// ----------------------------------------------------------------------------
//  channel  dir  carries
//  cfg      in   reg_index, write_data (font_base .. fallback_code)
//  req      in   op, block_index, range_start, range_end, code
//  rsp      out  glyph_address, used_fallback, not_found
//
// A load word is written into its table entry and gives no result.
// A lookup walks a row of MAX_BLOCKS cells, one cell per cycle, and walks it
// again when the fallback code is searched as well. req is ready only when
// idle. The table has no reset; cfg is always ready. A waiting result is held
// in the output register until taken and stalls only the final address step.
`include "assert_macros.svh"

module kanji_glyph_address_lookup_top
  import kgal_pkg::*;
(
  input logic clk,
  input logic rst,
  kgal_cfg_if.sink   cfg,
  kgal_req_if.sink   req,
  kgal_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_ADD  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [ADDR_W-1:0] font_base;
  logic [PIX_W-1:0]  glyph_width;
  logic [PIX_W-1:0]  glyph_height;
  logic [BC_W-1:0]   block_count;
  logic [CODE_W-1:0] fallback_code;

  logic              fallback_used;
  logic              missed;
  logic [ADDR_W-1:0] offs;
  logic [SIZE_W-1:0] glyph_size;
  logic [ADDR_W-1:0] base_sum;
  logic [ADDR_W-1:0] product;

  logic              rsp_valid;
  logic [ADDR_W-1:0] rsp_addr;
  logic              rsp_fb;
  logic              rsp_nf;

  tok_t  tok [MAX_BLOCKS+1];
  tok_t  chain_out;
  load_t load;

  logic req_take, lookup_take, walk_done, retry, rsp_free;
  logic [PIX_W:0]            width_round;
  logic [BPR_W-1:0]          row_bytes;
  logic [ADDR_W+SIZE_W-1:0]  product_full;

  assign req.ready   = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;
  assign req_take    = req.valid && req.ready;
  assign lookup_take = req_take && (req.op == OP_LOOKUP);
  assign chain_out   = tok[MAX_BLOCKS];
  assign walk_done   = (state == ST_WALK) && chain_out.valid;
  assign retry       = walk_done && !chain_out.hit && !fallback_used;
  assign rsp_free    = !rsp_valid || rsp.ready;

  assign load = '{we: req_take && (req.op == OP_LOAD), index: req.block_index,
                  first: req.range_start, last: req.range_end};

  // The first search starts from the request; a miss restarts it once with
  // the fallback code.
  assign tok[0] = '{valid: lookup_take || retry, hit: 1'b0,
                    code: (state == ST_IDLE) ? req.code : fallback_code,
                    acc: '0};

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    kgal_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cell_id     (BC_W'(g)),
      .block_count (block_count),
      .load        (load),
      .tok_in      (tok[g]),
      .tok_out     (tok[g+1])
    );
  end

  assign width_round  = {1'b0, glyph_width} + (PIX_W+1)'(7);
  assign row_bytes    = width_round[PIX_W:3];
  assign product_full = {{SIZE_W{1'b0}}, offs} * {{ADDR_W{1'b0}}, glyph_size};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (lookup_take) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          if (chain_out.hit) begin
            state_next = ST_MUL;
          end else if (fallback_used) begin
            state_next = ST_ADD;
          end
        end
      end
      ST_MUL: begin
        state_next = ST_ADD;
      end
      ST_ADD: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rsp_valid     <= 1'b0;
      font_base     <= '0;
      glyph_width   <= PIX_W'(16);
      glyph_height  <= PIX_W'(16);
      block_count   <= '0;
      fallback_code <= CODE_W'(33184);
    end else begin
      state <= state_next;
      if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if ((state == ST_ADD) && rsp_free) begin
        rsp_valid <= 1'b1;
      end
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.reg_index)
          CFG_FONT_BASE:     font_base     <= cfg.write_data;
          CFG_GLYPH_WIDTH:   glyph_width   <= cfg.write_data[PIX_W-1:0];
          CFG_GLYPH_HEIGHT:  glyph_height  <= cfg.write_data[PIX_W-1:0];
          CFG_BLOCK_COUNT:   block_count   <= cfg.write_data[BC_W-1:0];
          CFG_FALLBACK_CODE: fallback_code <= cfg.write_data[CODE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_take) begin
      fallback_used <= 1'b0;
      missed        <= 1'b0;
      glyph_size    <= SIZE_W'(row_bytes) * SIZE_W'(glyph_height);
      base_sum      <= font_base + ADDR_W'(HEADER_BYTES)
                     + {{(ADDR_W-BC_W-2){1'b0}}, block_count, 2'b00};
    end
    if (retry) begin
      fallback_used <= 1'b1;
    end
    if (walk_done && !chain_out.hit && fallback_used) begin
      missed <= 1'b1;
    end
    if (walk_done && chain_out.hit) begin
      offs <= chain_out.acc;
    end
    if (state == ST_MUL) begin
      product <= product_full[ADDR_W-1:0];
    end
    if ((state == ST_ADD) && rsp_free) begin
      rsp_addr <= missed ? '0 : (base_sum + product);
      rsp_fb   <= fallback_used;
      rsp_nf   <= missed;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.glyph_address = rsp_addr;
  assign rsp.used_fallback = rsp_fb;
  assign rsp.not_found     = rsp_nf;

  `KGAL_ASSERT_NOW(a_tok_only_in_walk, chain_out.valid, state == ST_WALK)
  `KGAL_ASSERT_NEXT(a_lookup_starts_walk, lookup_take, state == ST_WALK)
  `KGAL_ASSERT_NOW(a_nf_implies_fb, rsp_valid && rsp_nf, rsp_fb)
  `KGAL_ASSERT_NOW(a_nf_addr_zero, rsp_valid && rsp_nf, rsp_addr == '0)

endmodule

FILE: tb/sv/kanji_glyph_address_lookup_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kanji_glyph_address_lookup_top_tb
// Self-checking bench for the glyph address unit. Range loads and code lookups
// are driven over the request channel while a scoreboard predicts each glyph
// address, fallback flag and miss flag from its own copy of the block table
// and registers. Settings change only while the unit is idle.
// ----------------------------------------------------------------------------
module kanji_glyph_address_lookup_top_tb;
  import kgal_pkg::*;

  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  block_index;
    logic [CODE_W-1:0] range_start;
    logic [CODE_W-1:0] range_end;
    logic [CODE_W-1:0] code;
  } glyph_request_t;

  typedef struct packed {
    logic [ADDR_W-1:0] glyph_address;
    logic              used_fallback;
    logic              not_found;
  } glyph_result_t;

  class glyph_scoreboard;
    logic [CODE_W-1:0] lo_code[MAX_BLOCKS];
    logic [CODE_W-1:0] hi_code[MAX_BLOCKS];
    logic [ADDR_W-1:0] font_base;
    logic [PIX_W-1:0]  glyph_width;
    logic [PIX_W-1:0]  glyph_height;
    logic [BC_W-1:0]   block_count;
    logic [CODE_W-1:0] fallback_code;
    glyph_result_t     address_q[$];
    int errors, results_seen, loads, direct_hits, fallback_hits, unmapped;

    function new();
      font_base     = '0;
      glyph_width   = 8'd16;
      glyph_height  = 8'd16;
      block_count   = '0;
      fallback_code = 16'h81A0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        lo_code[i] = '0;
        hi_code[i] = '0;
      end
    endfunction

    function int pending();
      return address_q.size();
    endfunction

    function int walk_count();
      return (block_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_count);
    endfunction

    function void write_register(cfg_reg_t r, logic [ADDR_W-1:0] d);
      case (r)
        CFG_FONT_BASE:     font_base = d;
        CFG_GLYPH_WIDTH:   glyph_width = d[PIX_W-1:0];
        CFG_GLYPH_HEIGHT:  glyph_height = d[PIX_W-1:0];
        CFG_BLOCK_COUNT:   block_count = d[BC_W-1:0];
        CFG_FALLBACK_CODE: fallback_code = d[CODE_W-1:0];
        default: ;
      endcase
    endfunction

    // Walks the table in order; the glyph index is the sum of the sizes of the
    // ranges passed over plus the offset into the matching range. Reversed
    // ranges never match, but their size still wraps into the running sum.
    function bit find_range(logic [CODE_W-1:0] c, output logic [ADDR_W-1:0] gidx);
      logic [ADDR_W-1:0] prefix;
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      prefix = '0;
      gidx   = '0;
      for (int i = 0; i < walk_count(); i++) begin
        lo = 32'(lo_code[i]);
        hi = 32'(hi_code[i]);
        if (lo <= 32'(c) && 32'(c) <= hi) begin
          gidx = prefix + 32'(c) - lo;
          return 1'b1;
        end
        prefix = prefix + hi - lo + 32'd1;
      end
      return 1'b0;
    endfunction

    function void note_request(glyph_request_t r);
      glyph_result_t     res;
      logic [ADDR_W-1:0] gidx;
      logic [ADDR_W-1:0] gsize;
      if (r.op == OP_LOAD) begin
        lo_code[r.block_index] = r.range_start;
        hi_code[r.block_index] = r.range_end;
        loads++;
        return;
      end
      res = '0;
      if (!find_range(r.code, gidx)) begin
        res.used_fallback = 1'b1;
        if (!find_range(fallback_code, gidx))
          res.not_found = 1'b1;
      end
      if (!res.not_found) begin
        gsize = ((32'(glyph_width) + 32'd7) >> 3) * 32'(glyph_height);
        res.glyph_address = font_base + 32'(HEADER_BYTES) + 32'd4 * 32'(block_count)
                          + gidx * gsize;
      end
      if (res.not_found) unmapped++;
      else if (res.used_fallback) fallback_hits++;
      else direct_hits++;
      address_q.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task check_result(glyph_result_t got);
      glyph_result_t want;
      results_seen++;
      if (address_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding (addr %h)",
                         results_seen, got.glyph_address));
        return;
      end
      want = address_q.pop_front();
      if (got.glyph_address !== want.glyph_address)
        report($sformatf("result %0d glyph_address %h, predicted %h",
                         results_seen, got.glyph_address, want.glyph_address));
      if (got.used_fallback !== want.used_fallback)
        report($sformatf("result %0d used_fallback %b, predicted %b",
                         results_seen, got.used_fallback, want.used_fallback));
      if (got.not_found !== want.not_found)
        report($sformatf("result %0d not_found %b, predicted %b",
                         results_seen, got.not_found, want.not_found));
    endtask
  endclass

  logic clk;
  logic rst;

  kgal_cfg_if cfg_ch();
  kgal_req_if req_ch();
  kgal_rsp_if rsp_ch();

  kanji_glyph_address_lookup_top dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  glyph_scoreboard sb;
  int req_idle_pct;
  int rsp_idle_pct;
  int settings_applied;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Run stopped: no progress within the time limit.");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_result('{rsp_ch.glyph_address, rsp_ch.used_fallback, rsp_ch.not_found});
  end

  function automatic glyph_request_t make_load(logic [IDX_W-1:0] idx,
                                               logic [CODE_W-1:0] lo, logic [CODE_W-1:0] hi);
    return '{OP_LOAD, idx, lo, hi, 16'($urandom)};
  endfunction

  function automatic glyph_request_t make_lookup(logic [CODE_W-1:0] c);
    return '{OP_LOOKUP, 7'($urandom), 16'($urandom), 16'($urandom), c};
  endfunction

  // Mostly codes inside one of the first n ranges, with range edges and
  // arbitrary codes mixed in so that misses and fallbacks stay common.
  function automatic logic [CODE_W-1:0] pick_code(int n);
    int sel;
    int i;
    sel = $urandom_range(0, 99);
    if (n == 0 || sel < 20) return 16'($urandom);
    i = $urandom_range(0, n - 1);
    if (sb.lo_code[i] > sb.hi_code[i]) return 16'($urandom);
    if (sel < 30) return sb.lo_code[i];
    if (sel < 40) return sb.hi_code[i];
    return 16'($urandom_range(sb.lo_code[i], sb.hi_code[i]));
  endfunction

  function automatic glyph_request_t random_load(logic [IDX_W-1:0] idx);
    logic [CODE_W-1:0] lo;
    logic [CODE_W-1:0] hi;
    int sel;
    int span;
    sel  = $urandom_range(0, 99);
    lo   = 16'($urandom);
    hi   = 16'($urandom);
    span = $urandom_range(0, 400);
    if (sel < 70)
      hi = (32'(lo) + span > 32'hFFFF) ? 16'hFFFF : lo + 16'(span);
    else if (sel < 85 && lo < hi)
      return make_load(idx, hi, lo);
    return make_load(idx, lo, hi);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixels();
    case ($urandom_range(0, 19))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      3:       return 8'd8;
      4:       return 8'd9;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic send_req(glyph_request_t r);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.op          <= r.op;
    req_ch.block_index <= r.block_index;
    req_ch.range_start <= r.range_start;
    req_ch.range_end   <= r.range_end;
    req_ch.code        <= r.code;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(r);
  endtask

  // Waits until every predicted address has come back, then leaves a quiet
  // gap as long as a full double walk before moving on.
  task automatic drain_block();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * MAX_BLOCKS + 4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [ADDR_W-1:0] d);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.reg_index  <= r;
    cfg_ch.write_data <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_register(r, d);
  endtask

  task automatic apply_settings(input logic [ADDR_W-1:0] base, input logic [PIX_W-1:0] w,
                                input logic [PIX_W-1:0] h, input logic [BC_W-1:0] bc,
                                input logic [CODE_W-1:0] fb);
    drain_block();
    write_reg(CFG_FONT_BASE, base);
    write_reg(CFG_GLYPH_WIDTH, 32'(w));
    write_reg(CFG_GLYPH_HEIGHT, 32'(h));
    write_reg(CFG_BLOCK_COUNT, 32'(bc));
    write_reg(CFG_FALLBACK_CODE, 32'(fb));
    cfg_ch.valid <= 1'b0;
    settings_applied++;
  endtask

  // A negative bc_pick draws the block count at random.
  task automatic random_settings(int bc_pick);
    logic [ADDR_W-1:0] base;
    logic [BC_W-1:0]   bc;
    logic [CODE_W-1:0] fb;
    int sel;
    sel  = $urandom_range(0, 9);
    base = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : 32'($urandom);
    sel  = $urandom_range(0, 9);
    if (bc_pick >= 0)  bc = 8'(bc_pick);
    else if (sel == 0) bc = 8'd0;
    else if (sel == 1) bc = 8'd128;
    else if (sel == 2) bc = 8'($urandom_range(129, 255));
    else if (sel < 5)  bc = 8'($urandom_range(1, 8));
    else               bc = 8'($urandom_range(1, 128));
    fb = ($urandom_range(0, 9) < 7) ? pick_code((bc > MAX_BLOCKS) ? MAX_BLOCKS : int'(bc))
                                    : 16'($urandom);
    apply_settings(base, pick_pixels(), pick_pixels(), bc, fb);
  endtask

  initial begin
    logic [CODE_W-1:0] cursor;
    int span;
    sb = new();
    settings_applied   = 0;
    req_idle_pct       = 25;
    rsp_idle_pct       = 59;
    rst                <= 1'b1;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.reg_index   <= CFG_FONT_BASE;
    cfg_ch.write_data  <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.op          <= OP_LOAD;
    req_ch.block_index <= '0;
    req_ch.range_start <= '0;
    req_ch.range_end   <= '0;
    req_ch.code        <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With the reset block count of zero every lookup misses twice.
    send_req(make_lookup(16'h0000));
    send_req(make_lookup(16'hFFFF));
    send_req(make_load(7'd0, 16'h0000, 16'h00FF));
    send_req(make_load(7'd1, 16'h8140, 16'h81FF));
    send_req(make_load(7'd2, 16'h889F, 16'h88FC));
    send_req(make_load(7'd3, 16'h9100, 16'h9000));
    send_req(make_load(7'd4, 16'hFF00, 16'hFFFF));
    send_req(make_load(7'd127, 16'h1234, 16'h1234));
    apply_settings(32'h1000_0000, 8'd16, 8'd16, 8'd5, 16'h81A0);
    send_req(make_lookup(16'h0000));
    send_req(make_lookup(16'h00FF));
    send_req(make_lookup(16'h81A0));
    send_req(make_lookup(16'h88FC));
    send_req(make_lookup(16'h9050));
    send_req(make_lookup(16'hFFFF));
    send_req(make_lookup(16'h5000));
    apply_settings(32'h1000_0000, 8'd16, 8'd16, 8'd5, 16'h5000);
    send_req(make_lookup(16'h6000));
    apply_settings(32'hFFFF_FFF0, 8'd0, 8'd255, 8'd5, 16'h81A0);
    send_req(make_lookup(16'h00FF));
    apply_settings(32'hFFFF_FFFF, 8'd255, 8'd255, 8'd5, 16'h81A0);
    send_req(make_lookup(16'hFFFF));
    apply_settings(32'h0, 8'd9, 8'd0, 8'd5, 16'h81A0);
    send_req(make_lookup(16'h81A0));

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin req_idle_pct = 25; rsp_idle_pct = 59; end
        1: begin req_idle_pct = 59; rsp_idle_pct = 25; end
        default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
      endcase
      // Fill the whole table first, mostly with ascending ranges and now and then a
      // reversed one, so that any block count can be walked without touching an unwritten entry.
      if (ph == 0) begin
        cursor = 16'($urandom_range(0, 255));
        for (int i = 0; i < MAX_BLOCKS; i++) begin
          span = $urandom_range(1, 300);
          if ($urandom_range(0, 19) == 0)
            send_req(make_load(IDX_W'(i), cursor + 16'(span), cursor));
          else
            send_req(make_load(IDX_W'(i), cursor, cursor + 16'(span - 1)));
          cursor = cursor + 16'(span + $urandom_range(0, 150));
        end
      end
      for (int s = 0; s < 4; s++) begin
        if (s == 0 && ph == 0)      random_settings(255);
        else if (s == 0 && ph == 1) random_settings(128);
        else                        random_settings(-1);
        for (int k = 0; k < 35; k++) begin
          if ($urandom_range(0, 99) < 20)
            send_req(random_load(7'($urandom)));
          else
            send_req(make_lookup(pick_code(sb.walk_count())));
        end
      end
    end

    drain_block();
    if (sb.pending() != 0)
      sb.report($sformatf("%0d predicted results never arrived", sb.pending()));
    $display("Covered %0d range loads and %0d lookups over %0d register settings.",
             sb.loads, sb.direct_hits + sb.fallback_hits + sb.unmapped, settings_applied);
    $display("Lookups: %0d direct hits, %0d fallback hits, %0d unmapped; %0d errors.",
             sb.direct_hits, sb.fallback_hits, sb.unmapped, sb.errors);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
